/* design/ifa_pkg.sv */
`default_nettype none
package ifa_pkg;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_PFX   = 4'b0100,
    ST_DIGIT = 4'b1000
  } state_t;

  localparam logic [1:0] KIND_SDEC = 2'd0;
  localparam logic [1:0] KIND_UDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_PTR  = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;

  localparam int unsigned DEC_DIGITS = 10;
  localparam int unsigned BIN_BITS   = 32;

endpackage
`default_nettype wire

/* design/integer_to_ascii_formatter_unit.sv */
// Channel   Ports                                          Handshake
// input     in_kind, in_value, in_upper_case               start & !busy
// result    out_ch, out_char_index, out_last               out_valid, one cycle
//
// Decimal kinds: the value is loaded, then converted by double-dabble on the BCD
// shift/adjust unit, then the characters are shown, with the leading zero
// digits skipped. Hex and pointer kinds skip the conversion.
// busy is high from acceptance to the last char.
// rst_n is synchronous; it returns the sequencer to idle.
// The receiver cannot stall: each character is shown for one cycle only.
`default_nettype none
module integer_to_ascii_formatter_unit
  import ifa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_value,
  input  wire logic        in_upper_case,
  output logic             out_valid,
  output logic [7:0]       out_ch,
  output logic [4:0]       out_char_index,
  output logic             out_last
);

  state_t      state_r, state_nxt;
  logic [63:0] dig_r, dig_nxt;
  logic [31:0] bin_r, bin_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [4:0]  rem_r, rem_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        lead_r, lead_nxt;
  logic        ptr_r, ptr_nxt;
  logic        neg_r, neg_nxt;
  logic        up_r, up_nxt;

  logic [31:0] low;
  logic [31:0] mag;
  logic [39:0] bcd_adj;
  logic [3:0]  top;
  logic        skip;
  logic [7:0]  dig_ch;

  assign low  = in_value[31:0];
  assign mag  = (in_kind == KIND_SDEC && low[31]) ? (~low + 32'd1) : low;
  assign top  = dig_r[63:60];
  assign skip = lead_r && (top == 4'd0) && (rem_r != 5'd1);

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (dig_r[24 + i*4 +: 4] >= 4'd5) ?
                          dig_r[24 + i*4 +: 4] + 4'd3 : dig_r[24 + i*4 +: 4];
    end
  end

  always_comb begin
    if (top < 4'd10) begin
      dig_ch = CH_ZERO + {4'd0, top};
    end else begin
      dig_ch = (up_r ? CH_UA : CH_LA) + {4'd0, top} - 8'd10;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    bin_nxt   = bin_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    lead_nxt  = lead_r;
    ptr_nxt   = ptr_r;
    neg_nxt   = neg_r;
    up_nxt    = up_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          idx_nxt  = 5'd0;
          lead_nxt = 1'b1;
          ptr_nxt  = (in_kind == KIND_PTR);
          neg_nxt  = (in_kind == KIND_SDEC) && low[31];
          up_nxt   = (in_kind == KIND_HEX) && in_upper_case;
          bin_nxt  = mag;
          cnt_nxt  = 5'(BIN_BITS - 1);
          case (in_kind)
            KIND_SDEC, KIND_UDEC: begin
              dig_nxt   = 64'd0;
              rem_nxt   = 5'(DEC_DIGITS);
              state_nxt = ST_CONV;
            end
            KIND_HEX: begin
              dig_nxt   = {low, 32'd0};
              rem_nxt   = 5'd8;
              state_nxt = ST_DIGIT;
            end
            default: begin
              dig_nxt   = in_value;
              rem_nxt   = 5'd16;
              state_nxt = ST_PFX;
            end
          endcase
        end
      end
      ST_CONV: begin
        dig_nxt = {bcd_adj[38:0], bin_r[31], 24'd0};
        bin_nxt = {bin_r[30:0], 1'b0};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = neg_r ? ST_PFX : ST_DIGIT;
        end
      end
      ST_PFX: begin
        idx_nxt = idx_r + 5'd1;
        if (!ptr_r || idx_r == 5'd1) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        dig_nxt = {dig_r[59:0], 4'd0};
        rem_nxt = rem_r - 5'd1;
        if (!skip) begin
          lead_nxt = 1'b0;
          idx_nxt  = idx_r + 5'd1;
          if (rem_r == 5'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dig_r  <= dig_nxt;
    bin_r  <= bin_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    idx_r  <= idx_nxt;
    lead_r <= lead_nxt;
    ptr_r  <= ptr_nxt;
    neg_r  <= neg_nxt;
    up_r   <= up_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_PFX) || ((state_r == ST_DIGIT) && !skip);
  assign out_char_index = idx_r;
  assign out_last       = (state_r == ST_DIGIT) && (rem_r == 5'd1);
  always_comb begin
    if (state_r == ST_PFX) begin
      out_ch = ptr_r ? ((idx_r == 5'd0) ? CH_ZERO : CH_X) : CH_MINUS;
    end else begin
      out_ch = dig_ch;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("character outside a transaction");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !busy) else $error("transaction not ended by last");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_index <= 5'd17) else $error("character index overrun");

endmodule
`default_nettype wire
